>>> hdl/cqpg_pkg.sv
// cqpg_pkg: shared types and widths for the circle quadrant point generator
// no dependencies; used by the controller, the datapath and the top level
package cqpg_pkg;

    localparam int CoordW  = 12;
    localparam int RadW    = 6;
    localparam int RowW    = 8;
    localparam int SqW     = 13;
    localparam int LimW    = 12;
    localparam int XOutW   = 13;
    localparam int YOutW   = 14;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic done_col;
    } t_status;

endpackage

>>> hdl/cqpg_ctrl.sv
// cqpg_ctrl: sequencing state machine for the circle quadrant point generator
// depends on cqpg_pkg (command and status structs)
module cqpg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_emit,
    output cqpg_pkg::t_cmd   o_cmd,
    input  cqpg_pkg::t_status i_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = i_status.done_col ? S_EMIT : S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.done_col ? S_EMIT : S_DEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_emit = (r_state == S_EMIT);

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_emit)
        else $error("result strobe while idle");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_emit)
        else $error("accepted request did not reach emit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && i_status.last) |=> !busy)
        else $error("block still busy after last result");

    a_no_step_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("load and step together");

endmodule

>>> hdl/cqpg_datapath.sv
// cqpg_datapath: centre, offset and incremental square registers plus output adders
// depends on cqpg_pkg (widths, command and status structs)
module cqpg_datapath #(
    parameter int MAX_RADIUS = 63
) (
    input  logic                                    i_clk,
    input  cqpg_pkg::t_cmd                          i_cmd,
    output cqpg_pkg::t_status                       o_status,
    input  logic [cqpg_pkg::CoordW-1:0]             i_center_x,
    input  logic [cqpg_pkg::CoordW-1:0]             i_center_y,
    input  logic [cqpg_pkg::RadW-1:0]               i_radius,
    output logic [cqpg_pkg::XOutW-1:0]              o_right_x,
    output logic signed [cqpg_pkg::XOutW-1:0]       o_left_x,
    output logic signed [cqpg_pkg::YOutW-1:0]       o_lower_y,
    output logic signed [cqpg_pkg::YOutW-1:0]       o_upper_y
);

    localparam logic [cqpg_pkg::RadW-1:0] MaxRad = cqpg_pkg::RadW'(MAX_RADIUS);

    logic [cqpg_pkg::CoordW-1:0]      r_cx;
    logic [cqpg_pkg::CoordW-1:0]      r_cy;
    logic [cqpg_pkg::RadW-1:0]        r_rad;
    logic [cqpg_pkg::RadW-1:0]        r_x;
    logic signed [cqpg_pkg::RowW-1:0] r_y;
    logic [cqpg_pkg::SqW-1:0]         r_xsq;
    logic [cqpg_pkg::SqW-1:0]         r_ysq;
    logic [cqpg_pkg::LimW-1:0]        r_limit;

    logic [cqpg_pkg::RadW-1:0]        rad_sat;
    logic [cqpg_pkg::LimW-1:0]        rad_sq;
    logic [cqpg_pkg::SqW:0]           sq_sum;
    logic                             cond;
    logic                             y_le1;
    logic [cqpg_pkg::SqW+1:0]         y_dbl;
    logic [cqpg_pkg::SqW+1:0]         ysq_dec;
    logic [cqpg_pkg::SqW-1:0]         xsq_inc;

    assign rad_sat = (i_radius > MaxRad) ? MaxRad : i_radius;
    assign rad_sq  = cqpg_pkg::LimW'(rad_sat) * cqpg_pkg::LimW'(rad_sat);

    assign sq_sum = {1'b0, r_xsq} + {1'b0, r_ysq};
    assign cond   = sq_sum >= {2'b00, r_limit};
    assign y_le1  = r_y <= 8'sd1;

    assign y_dbl   = {{(cqpg_pkg::SqW+1-cqpg_pkg::RowW){r_y[cqpg_pkg::RowW-1]}}, r_y, 1'b0};
    assign ysq_dec = {2'b00, r_ysq} - y_dbl + 15'd1;
    assign xsq_inc = r_xsq + cqpg_pkg::SqW'({r_x, 1'b0}) + 13'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_rad   <= rad_sat;
            r_x     <= '0;
            r_y     <= cqpg_pkg::RowW'(rad_sat);
            r_xsq   <= '0;
            r_ysq   <= cqpg_pkg::SqW'(rad_sq);
            r_limit <= rad_sq - cqpg_pkg::LimW'(rad_sat);
        end else if (i_cmd.step) begin
            if (cond) begin
                r_y   <= r_y - 8'sd1;
                r_ysq <= ysq_dec[cqpg_pkg::SqW-1:0];
            end
            if (!cond || y_le1) begin
                r_x   <= r_x + 6'd1;
                r_xsq <= xsq_inc;
            end
        end
    end

    assign o_status.last     = (r_x == r_rad);
    assign o_status.done_col = !cond || y_le1;

    assign o_right_x = cqpg_pkg::XOutW'(r_cx) + cqpg_pkg::XOutW'(r_x);
    assign o_left_x  = cqpg_pkg::XOutW'(r_cx) - cqpg_pkg::XOutW'(r_x);
    assign o_lower_y = $signed(cqpg_pkg::YOutW'(r_cy)) + cqpg_pkg::YOutW'(r_y);
    assign o_upper_y = $signed(cqpg_pkg::YOutW'(r_cy)) - cqpg_pkg::YOutW'(r_y);

endmodule

>>> hdl/circle_quadrant_point_generator_unit.sv
// circle_quadrant_point_generator_unit: top level joining controller and datapath
// depends on cqpg_pkg, cqpg_ctrl and cqpg_datapath
//
// A request (centre i_center_x, i_center_y and radius i_radius) is taken on the
// rising edge where start is high and busy is low. Radii above MAX_RADIUS are
// clamped. The block then walks one quadrant and delivers r+1 results, one per
// column x = 0..r, each as the mirrored coordinates o_right_x, o_left_x,
// o_lower_y and o_upper_y, valid for one cycle while o_strobe is high; the
// result for x = r carries o_last.
// The first result appears in the cycle after the request. Each column is
// emitted from the EMIT state; where the midpoint walk takes extra row steps in
// it, the controller steps through the DEC state before the column advances. A
// single step unit makes each row decrement and column advance, one step per
// cycle. busy drops in the
// cycle after the last result, and the next request may be taken then.
// Results cannot be held off: the receiver must take each strobed result.
// Synchronous reset returns the block to idle with busy low.
module circle_quadrant_point_generator_unit #(
    parameter int MAX_RADIUS = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cqpg_pkg::CoordW-1:0]         i_center_x,
    input  logic [cqpg_pkg::CoordW-1:0]         i_center_y,
    input  logic [cqpg_pkg::RadW-1:0]           i_radius,
    output logic                                o_strobe,
    output logic [cqpg_pkg::XOutW-1:0]          o_right_x,
    output logic signed [cqpg_pkg::XOutW-1:0]   o_left_x,
    output logic signed [cqpg_pkg::YOutW-1:0]   o_lower_y,
    output logic signed [cqpg_pkg::YOutW-1:0]   o_upper_y,
    output logic                                o_last
);

    cqpg_pkg::t_cmd    cmd;
    cqpg_pkg::t_status status;

    cqpg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_emit   (o_strobe),
        .o_cmd    (cmd),
        .i_status (status)
    );

    cqpg_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_right_x  (o_right_x),
        .o_left_x   (o_left_x),
        .o_lower_y  (o_lower_y),
        .o_upper_y  (o_upper_y)
    );

    assign o_last = status.last;

endmodule
